[design/lsbs_pkg.sv]
// Shared definitions for the light style brightness sequencer: field widths,
// mode and style codes, pattern strings, pattern lengths and the pattern lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsbs_pkg;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int NOW_W    = 32;
    localparam int PICK_W   = 3;
    localparam int STYLE_W  = 4;
    localparam int LVL_W    = 4;

    // Stream word widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // Parameter defaults
    localparam int DEF_TIME_WIDTH = 32;
    localparam int DEF_SLOT_SHIFT = 5;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;

    // Style codes
    localparam logic [STYLE_W-1:0] STYLE_NONE     = 4'd0;
    localparam logic [STYLE_W-1:0] STYLE_SINE     = 4'd1;
    localparam logic [STYLE_W-1:0] STYLE_FADE_IN  = 4'd2;
    localparam logic [STYLE_W-1:0] STYLE_FADE_OUT = 4'd3;
    localparam logic [STYLE_W-1:0] STYLE_FADE_IO  = 4'd4;
    localparam logic [STYLE_W-1:0] STYLE_NEON     = 4'd5;
    localparam logic [STYLE_W-1:0] STYLE_BROKEN   = 4'd6;
    localparam logic [STYLE_W-1:0] STYLE_ARC      = 4'd7;
    localparam logic [STYLE_W-1:0] STYLE_FIRE     = 4'd8;

    // Timing thresholds in ms
    localparam int FADE_MS     = 1000;
    localparam int NEON_END_MS = 2000;

    // Pattern strings, first character in the top byte
    localparam PAT_SINE_S   = "ABCDEFGHIJKLMNOPPONMLKJIHGFEDCBA";
    localparam PAT_UP_S     =
        "ABCDEFGHIJKLMNOPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPPP";
    localparam PAT_DOWN_S   =
        "PONMLKJIHGFEDCBAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA";
    localparam PAT_BROKEN_S = "PAAPAPPAPAAAPAPPAAAAPAAPPPPAPAAAPAAPAAAAPAAPAAAAAAAAAPPPP";
    localparam PAT_SPARK_S  =
        "PAPAPAPAPAPAAAAAAAAAAAAAAAAAAAAAAAAPAPAPAPAAAAAAAAAAAAAPAPAAAAAAAAAAA";
    localparam PAT_FLAME_S  = "FFFFFFFFFF8FFFFFFFF8FFFFF8F8FFF8FFFFFFFFFFFF8FFFFFFF";
    localparam PAT_N0_S     = "PAPAPPAPAAAPAPPAAAAPAAPPAPAAAPAAPAAAAPAAPAAAPAAPAAAP";
    localparam PAT_N1_S     = "APPPAPPAPPAAAAAPAPPAAAAAAAAAAPAAAAPAAAAPAAAAAPAAAAPA";
    localparam PAT_N2_S     = "AAAAAAAPAAAAAPAAAPPPPPPPPPPAAAAAAAPPPPPAPPPPPPPAAAAA";
    localparam PAT_N3_S     = "APAPPPAPAAAAAPPAAAPAPPAAPAPAAAPAPPPAAAPAPPPAPAPAAAPA";
    localparam PAT_N4_S     = "PPPPAPPPPPAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAPPAPPPPAPPPP";
    localparam PAT_N5_S     = "PPPPPPPPPAPPPPPPPPPAPAAAAPPPPPPPAAAAAAPPPPAAAAPPPPPP";
    localparam PAT_N6_S     = "AAPPPAPPAPPPAPAAPPPAPAAPAPAPAPAPPAPPPAAAPAPPAAPPAPAA";
    localparam PAT_N7_S     = "PPAPAAPPAPAPAAAPAPPPAAPPAPAPAPPAPPPAPPPPAAPPAPAPAPPA";

    localparam int LEN_SINE   = $bits(PAT_SINE_S) / 8;
    localparam int LEN_UP     = $bits(PAT_UP_S) / 8;
    localparam int LEN_DOWN   = $bits(PAT_DOWN_S) / 8;
    localparam int LEN_BROKEN = $bits(PAT_BROKEN_S) / 8;
    localparam int LEN_SPARK  = $bits(PAT_SPARK_S) / 8;
    localparam int LEN_FLAME  = $bits(PAT_FLAME_S) / 8;
    localparam int LEN_NEON   = $bits(PAT_N0_S) / 8;

    typedef enum logic [2:0] {
        PAT_SINE,
        PAT_UP,
        PAT_DOWN,
        PAT_BROKEN,
        PAT_SPARK,
        PAT_FLAME,
        PAT_NEON
    } t_pat;

    localparam int NPAT = 7;
    localparam int LEN_TAB [NPAT] = '{LEN_SINE, LEN_UP, LEN_DOWN, LEN_BROKEN,
                                      LEN_SPARK, LEN_FLAME, LEN_NEON};

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    localparam int LEN_MAX = imax(imax(imax(LEN_SINE, LEN_UP), imax(LEN_DOWN, LEN_BROKEN)),
                                  imax(imax(LEN_SPARK, LEN_FLAME), LEN_NEON));
    localparam int LEN_MIN = imin(imin(imin(LEN_SINE, LEN_UP), imin(LEN_DOWN, LEN_BROKEN)),
                                  imin(imin(LEN_SPARK, LEN_FLAME), LEN_NEON));
    localparam int SLOT_W  = $clog2(LEN_MAX);

    // Level at one slot of a pattern; letters map A..P to 0..15, the flame
    // pattern is read as hex digits.
    function automatic logic [LVL_W-1:0] pat_level(input t_pat p,
                                                   input logic [PICK_W-1:0] n,
                                                   input logic [SLOT_W-1:0] s);
        int         i;
        logic [7:0] c;
        i = int'(s);
        c = "A";
        case (p)
            PAT_SINE:   c = PAT_SINE_S[8*(LEN_SINE-1-i) +: 8];
            PAT_UP:     c = PAT_UP_S[8*(LEN_UP-1-i) +: 8];
            PAT_DOWN:   c = PAT_DOWN_S[8*(LEN_DOWN-1-i) +: 8];
            PAT_BROKEN: c = PAT_BROKEN_S[8*(LEN_BROKEN-1-i) +: 8];
            PAT_SPARK:  c = PAT_SPARK_S[8*(LEN_SPARK-1-i) +: 8];
            PAT_FLAME:  c = PAT_FLAME_S[8*(LEN_FLAME-1-i) +: 8];
            PAT_NEON: begin
                unique case (n)
                    3'd0: c = PAT_N0_S[8*(LEN_NEON-1-i) +: 8];
                    3'd1: c = PAT_N1_S[8*(LEN_NEON-1-i) +: 8];
                    3'd2: c = PAT_N2_S[8*(LEN_NEON-1-i) +: 8];
                    3'd3: c = PAT_N3_S[8*(LEN_NEON-1-i) +: 8];
                    3'd4: c = PAT_N4_S[8*(LEN_NEON-1-i) +: 8];
                    3'd5: c = PAT_N5_S[8*(LEN_NEON-1-i) +: 8];
                    3'd6: c = PAT_N6_S[8*(LEN_NEON-1-i) +: 8];
                    3'd7: c = PAT_N7_S[8*(LEN_NEON-1-i) +: 8];
                endcase
            end
            default: c = "A";
        endcase
        if (p == PAT_FLAME) begin
            return (c < "A") ? c[3:0] : c[3:0] + 4'd9;
        end
        return c[3:0] - 4'd1;
    endfunction

endpackage

`default_nettype wire

[design/light_style_brightness_sequencer.sv]
// Throughput: one word per cycle while the result stream is not stalled; the five
// register stages (state read-modify-write, chunk fold, reciprocal multiply,
// remainder with pattern lookup, output) advance in that order, each holding while
// the next stage is full and stalled; the state entry is forwarded between neighbors.
// Reset (i_rst_n low at a clock edge): style 0, pipeline empty, state entry reads
// as its reset value (light on, nothing pending, change time 0, neon pattern 0).
// Top level of the light style brightness sequencer; uses lsbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module light_style_brightness_sequencer
    import lsbs_pkg::*;
#(
    parameter int TIME_WIDTH = DEF_TIME_WIDTH,
    parameter int SLOT_SHIFT = DEF_SLOT_SHIFT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // style register write
    input  wire logic                 i_cfg_we,
    input  wire logic [STYLE_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] now_ms, [34:32] random_pick
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,  // [1:0] mode
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // [3:0] brightness
    output logic [M_TUSER_W-1:0]      m_axis_tuser   // [0] apply
);

    // ------------------------------------------------------------------
    // Derived sizes for the slot modulo unit
    // ------------------------------------------------------------------
    localparam int SLOT_BITS = TIME_WIDTH - SLOT_SHIFT;
    localparam int NCH       = (SLOT_BITS + 7) / 8;              // byte chunks of the slot
    localparam int CHW       = 8 * NCH;
    localparam int LW        = $clog2(LEN_MAX + 1);              // pattern length and weights
    localparam int R1W       = $clog2(NCH * 255 * (LEN_MAX - 1) + 1);
    localparam int MW        = $clog2((2 ** R1W) / LEN_MIN + 1);  // reciprocal width
    localparam int PW        = R1W + MW;

    typedef enum logic [2:0] {
        RULE_NONE,   // no write
        RULE_FULL,   // write 15
        RULE_DARK,   // write 0
        RULE_LOOP,   // write the looping pattern
        RULE_FADE,   // write the pattern during the fade window
        RULE_NEON    // neon pattern during the fade window, then full until the end
    } t_rule;

    typedef struct packed {
        logic                  lit;
        logic                  changed;
        logic [TIME_WIDTH-1:0] change_time;
        logic [PICK_W-1:0]     neon;
    } t_state;

    localparam t_state STATE_RST = '{lit: 1'b1, changed: 1'b0, change_time: '0, neon: '0};

    // ------------------------------------------------------------------
    // Constant tables for the modulo unit: chunk weights 256^k mod L,
    // reciprocals floor(2^R1W / L) and the lengths themselves.
    // ------------------------------------------------------------------
    logic [LW-1:0] w_tab [NPAT][NCH];
    logic [MW-1:0] m_tab [NPAT];
    logic [LW-1:0] l_tab [NPAT];

    for (genvar gp = 0; gp < NPAT; gp++) begin : g_pat
        localparam longint unsigned MV = (64'd1 << R1W) / longint'(LEN_TAB[gp]);
        assign m_tab[gp] = MW'(MV);
        assign l_tab[gp] = LW'(LEN_TAB[gp]);
        for (genvar gk = 0; gk < NCH; gk++) begin : g_chunk
            localparam longint unsigned WV = (64'd1 << (8 * gk)) % longint'(LEN_TAB[gp]);
            assign w_tab[gp][gk] = LW'(WV);
        end
    end

    // ------------------------------------------------------------------
    // Style register
    // ------------------------------------------------------------------
    logic [STYLE_W-1:0] r_style;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style <= STYLE_NONE;
        end else if (i_cfg_we) begin
            r_style <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when it is empty or drains.
    // ------------------------------------------------------------------
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_o_vld;
    logic rdy1, rdy2, rdy3, rdy4, rdy_o;
    logic s_acc;

    assign rdy_o = !r_o_vld  || m_axis_tready;
    assign rdy4  = !r_s4_vld || rdy_o;
    assign rdy3  = !r_s3_vld || rdy4;
    assign rdy2  = !r_s2_vld || rdy3;
    assign rdy1  = !r_s1_vld || rdy2;
    assign s_acc = s_axis_tvalid && rdy1;

    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (rdy1) r_s1_vld <= s_axis_tvalid;
            if (rdy2) r_s2_vld <= r_s1_vld;
            if (rdy3) r_s3_vld <= r_s2_vld;
            if (rdy4) r_s4_vld <= r_s3_vld;
            if (rdy_o) r_o_vld <= r_s4_vld;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input word and state entry read
    // The state memory has one entry; the read is issued at the accept edge
    // and lands next to the word. A write-back at that same edge is missed by
    // the read, so it is forwarded.
    // ------------------------------------------------------------------
    t_state              r_mem [1];
    logic                r_mem_vld;      // entry written since reset
    t_state              r_rd;
    logic                r_rd_vld;
    t_state              r_fwd_data;
    logic                r_fwd_hit;
    logic [MODE_W-1:0]   r_s1_mode;
    logic [NOW_W-1:0]    r_s1_now;
    logic [PICK_W-1:0]   r_s1_pick;

    t_state                s1_cur;
    t_state                n_state;
    logic [TIME_WIDTH-1:0] s1_now_t;
    logic [TIME_WIDTH-1:0] s1_elapsed;
    t_rule                 s1_rule;
    t_pat                  s1_pat;
    logic                  wr_en;

    assign wr_en = r_s1_vld && rdy2;

    always_comb begin
        s1_cur     = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd : STATE_RST);
        s1_now_t   = TIME_WIDTH'(r_s1_now);
        s1_elapsed = s1_now_t - s1_cur.change_time;
        n_state    = s1_cur;
        s1_rule    = RULE_NONE;
        s1_pat     = PAT_SINE;
        unique case (r_s1_mode)
            MODE_ON, MODE_OFF: begin
                // switch only when the light really changes
                if (s1_cur.lit != (r_s1_mode == MODE_ON)) begin
                    n_state.lit         = (r_s1_mode == MODE_ON);
                    n_state.changed     = 1'b1;
                    n_state.change_time = s1_now_t;
                end
            end
            MODE_TICK: begin
                n_state.changed = 1'b0;
                if (s1_cur.lit) begin
                    unique case (r_style)
                        STYLE_NONE: begin
                            s1_rule = s1_cur.changed ? RULE_FULL : RULE_NONE;
                        end
                        STYLE_SINE: begin
                            s1_rule = RULE_LOOP;
                            s1_pat  = PAT_SINE;
                        end
                        STYLE_FADE_IN, STYLE_FADE_IO: begin
                            s1_rule = RULE_FADE;
                            s1_pat  = PAT_UP;
                        end
                        STYLE_NEON: begin
                            // draw a fresh neon pattern on the first tick after a switch
                            if (s1_cur.changed) begin
                                n_state.neon = r_s1_pick;
                            end
                            s1_rule = RULE_NEON;
                            s1_pat  = PAT_NEON;
                        end
                        STYLE_BROKEN: begin
                            s1_rule = RULE_LOOP;
                            s1_pat  = PAT_BROKEN;
                        end
                        STYLE_ARC: begin
                            s1_rule = RULE_LOOP;
                            s1_pat  = PAT_SPARK;
                        end
                        STYLE_FIRE: begin
                            s1_rule = RULE_LOOP;
                            s1_pat  = PAT_FLAME;
                        end
                        default: s1_rule = RULE_NONE;
                    endcase
                end else begin
                    unique case (r_style)
                        STYLE_FADE_OUT, STYLE_FADE_IO: begin
                            s1_rule = RULE_FADE;
                            s1_pat  = PAT_DOWN;
                        end
                        STYLE_NONE, STYLE_SINE, STYLE_FADE_IN, STYLE_NEON,
                        STYLE_BROKEN, STYLE_ARC, STYLE_FIRE: begin
                            s1_rule = s1_cur.changed ? RULE_DARK : RULE_NONE;
                        end
                        default: s1_rule = RULE_NONE;
                    endcase
                end
            end
            default: ;  // unused mode: no state change, no write
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[0] <= n_state;
        end
        if (s_acc) begin
            r_rd       <= r_mem[0];
            r_fwd_data <= n_state;
            r_s1_mode  <= s_axis_tuser[MODE_W-1:0];
            r_s1_now   <= s_axis_tdata[NOW_W-1:0];
            r_s1_pick  <= s_axis_tdata[NOW_W +: PICK_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (wr_en) r_mem_vld <= 1'b1;
            if (s_acc) begin
                r_rd_vld  <= r_mem_vld;
                r_fwd_hit <= wr_en;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: resolve the write decision and fold the slot into a short sum
    // of byte chunks times 256^k mod L.
    // ------------------------------------------------------------------
    t_rule                 r_s2_rule;
    t_pat                  r_s2_pat;
    logic [PICK_W-1:0]     r_s2_neon;
    logic [TIME_WIDTH-1:0] r_s2_elapsed;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_rule    <= s1_rule;
            r_s2_pat     <= s1_pat;
            r_s2_neon    <= n_state.neon;
            r_s2_elapsed <= s1_elapsed;
        end
    end

    logic [SLOT_BITS-1:0] s2_slot;
    logic [CHW-1:0]       s2_slot_pad;
    logic                 s2_in_fade, s2_in_neon;
    logic                 n_s3_apply, n_s3_use_pat;
    logic [LVL_W-1:0]     n_s3_lvl;
    logic [R1W-1:0]       n_s3_r1;

    always_comb begin
        s2_slot      = r_s2_elapsed[TIME_WIDTH-1:SLOT_SHIFT];
        s2_slot_pad  = CHW'(s2_slot);
        s2_in_fade   = r_s2_elapsed < TIME_WIDTH'(FADE_MS);
        s2_in_neon   = r_s2_elapsed < TIME_WIDTH'(NEON_END_MS);
        n_s3_apply   = 1'b0;
        n_s3_use_pat = 1'b0;
        n_s3_lvl     = '0;
        unique case (r_s2_rule)
            RULE_FULL: begin
                n_s3_apply = 1'b1;
                n_s3_lvl   = '1;
            end
            RULE_DARK: n_s3_apply = 1'b1;
            RULE_LOOP: begin
                n_s3_apply   = 1'b1;
                n_s3_use_pat = 1'b1;
            end
            RULE_FADE: begin
                n_s3_apply   = s2_in_fade;
                n_s3_use_pat = s2_in_fade;
            end
            RULE_NEON: begin
                n_s3_apply   = s2_in_neon;
                n_s3_use_pat = s2_in_fade;
                n_s3_lvl     = '1;
            end
            default: ;
        endcase

        n_s3_r1 = '0;
        for (int k = 0; k < NCH; k++) begin
            n_s3_r1 = n_s3_r1 + R1W'(R1W'(s2_slot_pad[8*k +: 8]) * R1W'(w_tab[r_s2_pat][k]));
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient estimate by reciprocal multiply
    // ------------------------------------------------------------------
    logic              r_s3_apply, r_s3_use_pat;
    logic [LVL_W-1:0]  r_s3_lvl;
    t_pat              r_s3_pat;
    logic [PICK_W-1:0] r_s3_neon;
    logic [R1W-1:0]    r_s3_r1;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_apply   <= n_s3_apply;
            r_s3_use_pat <= n_s3_use_pat;
            r_s3_lvl     <= n_s3_lvl;
            r_s3_pat     <= r_s2_pat;
            r_s3_neon    <= r_s2_neon;
            r_s3_r1      <= n_s3_r1;
        end
    end

    logic [PW-1:0] s3_prod;

    assign s3_prod = PW'(r_s3_r1) * PW'(m_tab[r_s3_pat]);

    // ------------------------------------------------------------------
    // Stage 4: remainder with one correction step, then pattern lookup
    // ------------------------------------------------------------------
    logic              r_s4_apply, r_s4_use_pat;
    logic [LVL_W-1:0]  r_s4_lvl;
    t_pat              r_s4_pat;
    logic [PICK_W-1:0] r_s4_neon;
    logic [R1W-1:0]    r_s4_r1;
    logic [MW-1:0]     r_s4_q;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_apply   <= r_s3_apply;
            r_s4_use_pat <= r_s3_use_pat;
            r_s4_lvl     <= r_s3_lvl;
            r_s4_pat     <= r_s3_pat;
            r_s4_neon    <= r_s3_neon;
            r_s4_r1      <= r_s3_r1;
            r_s4_q       <= s3_prod[PW-1:R1W];
        end
    end

    logic [R1W-1:0]    s4_qm, s4_rem, s4_len;
    logic [SLOT_W-1:0] s4_slot;
    logic [LVL_W-1:0]  n_o_lvl;

    always_comb begin
        s4_len = R1W'(l_tab[r_s4_pat]);
        s4_qm  = R1W'(R1W'(r_s4_q) * s4_len);
        s4_rem = r_s4_r1 - s4_qm;
        // estimate is at most one short
        if (s4_rem >= s4_len) begin
            s4_rem = s4_rem - s4_len;
        end
        s4_slot = SLOT_W'(s4_rem);
        if (!r_s4_apply) begin
            n_o_lvl = '0;
        end else if (r_s4_use_pat) begin
            n_o_lvl = pat_level(r_s4_pat, r_s4_neon, s4_slot);
        end else begin
            n_o_lvl = r_s4_lvl;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold while the sink stalls
    // ------------------------------------------------------------------
    logic             r_o_apply;
    logic [LVL_W-1:0] r_o_lvl;

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_o_apply <= r_s4_apply;
            r_o_lvl   <= n_o_lvl;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {{(M_TDATA_W-LVL_W){1'b0}}, r_o_lvl};
    assign m_axis_tuser  = M_TUSER_W'(r_o_apply);

endmodule

`default_nettype wire

[design/lsbs_checker.sv]
// Port-level checks for the light style brightness sequencer, bound to the top.
// Depends on lsbs_pkg and light_style_brightness_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lsbs_checker
    import lsbs_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TUSER_W-1:0] s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a word with no write carries level zero
    a_no_apply_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("brightness set on a word without apply");

    // with the sink ready behind an accepted word, that word reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
            |=> m_axis_tvalid)
        else $error("result missing after fixed latency");

    // switch events and unused modes never write the light
    a_event_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && s_axis_tuser[MODE_W-1:0] != MODE_TICK) ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready ##1 m_axis_tready
            |=> m_axis_tvalid && !m_axis_tuser[0])
        else $error("switch event produced a light write");

endmodule

bind light_style_brightness_sequencer lsbs_checker u_lsbs_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for light_style_brightness_sequencer: a directed run and random
// event/tick runs in every style under varied stream back-pressure.
// Depends on lsbs_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module tb;
    import lsbs_pkg::*;

    // Timing and pattern-slot constants of the light behavior
    localparam int unsigned SLOT_SHIFT   = 5;
    localparam int unsigned FADE_SPAN_MS = 1000;
    localparam int unsigned NEON_SPAN_MS = 2000;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          RUN_WORDS    = 25;

    // Mode value the block must ignore
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;

    typedef struct packed {
        logic             apply;
        logic [LVL_W-1:0] level;
    } t_light_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [STYLE_W-1:0]   i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // [31:0] now_ms, [34:32] random_pick
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;  // [1:0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // [3:0] brightness
    logic [M_TUSER_W-1:0] m_axis_tuser;       // [0] apply

    // Shadow of the block's light state and style register
    logic [STYLE_W-1:0] style_reg = STYLE_NONE;
    logic               lamp_on = 1'b1;
    logic               change_pending = 1'b0;
    logic [NOW_W-1:0]   change_stamp = '0;
    logic [PICK_W-1:0]  neon_sel = '0;

    // Brightness words still owed by the block, oldest first
    t_light_word brightness_due [$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    light_style_brightness_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pattern strings per style; neon styles pick one of eight by the stored choice
    function automatic string pattern_of(input logic [STYLE_W-1:0] sty,
                                         input logic [PICK_W-1:0] sel);
        case (sty)
            STYLE_SINE:   return "ABCDEFGHIJKLMNOPPONMLKJIHGFEDCBA";
            STYLE_BROKEN: return "PAAPAPPAPAAAPAPPAAAAPAAPPPPAPAAAPAAPAAAAPAAPAAAAAAAAAPPPP";
            STYLE_ARC:
                return "PAPAPAPAPAPAAAAAAAAAAAAAAAAAAAAAAAAPAPAPAPAAAAAAAAAAAAAPAPAAAAAAAAAAA";
            STYLE_FIRE:   return "FFFFFFFFFF8FFFFFFFF8FFFFF8F8FFF8FFFFFFFFFFFF8FFFFFFF";
            default: begin
                case (sel)
                    3'd0: return "PAPAPPAPAAAPAPPAAAAPAAPPAPAAAPAAPAAAAPAAPAAAPAAPAAAP";
                    3'd1: return "APPPAPPAPPAAAAAPAPPAAAAAAAAAAPAAAAPAAAAPAAAAAPAAAAPA";
                    3'd2: return "AAAAAAAPAAAAAPAAAPPPPPPPPPPAAAAAAAPPPPPAPPPPPPPAAAAA";
                    3'd3: return "APAPPPAPAAAAAPPAAAPAPPAAPAPAAAPAPPPAAAPAPPPAPAPAAAPA";
                    3'd4: return "PPPPAPPPPPAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAPPAPPPPAPPPP";
                    3'd5: return "PPPPPPPPPAPPPPPPPPPAPAAAAPPPPPPPAAAAAAPPPPAAAAPPPPPP";
                    3'd6: return "AAPPPAPPAPPPAPAAPPPAPAAPAPAPAPAPPAPPPAAAPAPPAAPPAPAA";
                    default: return "PPAPAAPPAPAPAAAPAPPPAAPPAPAPAPPAPPPAPPPPAAPPAPAPAPPA";
                endcase
            end
        endcase
    endfunction

    // Read the level at the time slot of elapsed, wrapping around the pattern.
    // Letters A..P are 0..15; the fire pattern reads as hex digits.
    function automatic logic [LVL_W-1:0] pattern_level(input string pat,
                                                       input logic [NOW_W-1:0] elapsed,
                                                       input bit hex_digits);
        int unsigned slot;
        logic [7:0]  c;
        slot = (elapsed >> SLOT_SHIFT) % pat.len();
        c = pat[slot];
        if (hex_digits && c < "A")
            return LVL_W'(c - "0");
        if (hex_digits)
            return LVL_W'(c - "A" + 8'd10);
        return LVL_W'(c - "A");
    endfunction

    // Advance the shadow state by one accepted word and queue the brightness it owes
    task automatic predict_brightness(input logic [MODE_W-1:0] mode,
                                      input logic [NOW_W-1:0] now,
                                      input logic [PICK_W-1:0] pick);
        logic [NOW_W-1:0] elapsed;
        int unsigned      slot;
        t_light_word      due;
        due = '0;
        elapsed = now - change_stamp;
        slot = elapsed >> SLOT_SHIFT;
        if (mode == MODE_ON || mode == MODE_OFF) begin
            if (lamp_on != (mode == MODE_ON)) begin
                lamp_on = (mode == MODE_ON);
                change_pending = 1'b1;
                change_stamp = now;
            end
        end else if (mode == MODE_TICK) begin
            if (lamp_on) begin
                case (style_reg)
                    STYLE_NONE: begin
                        if (change_pending)
                            due = '{1'b1, 4'd15};
                    end
                    STYLE_SINE, STYLE_BROKEN, STYLE_ARC, STYLE_FIRE: begin
                        due.apply = 1'b1;
                        due.level = pattern_level(pattern_of(style_reg, '0), elapsed,
                                                  style_reg == STYLE_FIRE);
                    end
                    STYLE_FADE_IN, STYLE_FADE_IO: begin
                        // ramp A..P, then hold at P
                        if (elapsed < FADE_SPAN_MS)
                            due = '{1'b1, (slot > 15) ? 4'd15 : slot[3:0]};
                    end
                    STYLE_NEON: begin
                        if (change_pending)
                            neon_sel = pick;
                        if (elapsed < FADE_SPAN_MS) begin
                            due.apply = 1'b1;
                            due.level = pattern_level(pattern_of(STYLE_NEON, neon_sel),
                                                      elapsed, 1'b0);
                        end else if (elapsed < NEON_SPAN_MS) begin
                            due = '{1'b1, 4'd15};
                        end
                    end
                    default: ;
                endcase
            end else begin
                case (style_reg)
                    STYLE_NONE, STYLE_SINE, STYLE_FADE_IN, STYLE_NEON,
                    STYLE_BROKEN, STYLE_ARC, STYLE_FIRE: begin
                        if (change_pending)
                            due = '{1'b1, 4'd0};
                    end
                    STYLE_FADE_OUT, STYLE_FADE_IO: begin
                        // ramp P..A, then hold at A
                        if (elapsed < FADE_SPAN_MS)
                            due = '{1'b1, (slot > 15) ? 4'd0 : 4'd15 - slot[3:0]};
                    end
                    default: ;
                endcase
            end
            change_pending = 1'b0;
        end
        brightness_due.push_back(due);
    endtask

    // Offer one word, idling the sender first at random, and hold it until taken
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [NOW_W-1:0] now,
                             input logic [PICK_W-1:0] pick);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {5'd0, pick, now};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_brightness(mode, now, pick);
    endtask

    // Write the style register once every owed word is back, so the block is idle
    task automatic set_style(input logic [STYLE_W-1:0] sty);
        s_axis_tvalid <= 1'b0;
        while (brightness_due.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sty;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        style_reg = sty;
    endtask

    // Field extremes, redundant switches, the ignored mode, time wrap, the neon
    // window edges, the fade edges and an unused style
    task automatic test_directed();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_style(STYLE_NONE);
        send_word(MODE_TICK, 32'h0000_0000, 3'd0);
        send_word(MODE_ON,   32'h0000_0000, 3'd0);
        send_word(MODE_OFF,  32'hFFFF_FFF0, 3'd0);
        send_word(MODE_OFF,  32'h1234_5678, 3'd7);
        send_word(MODE_TICK, 32'h0000_0100, 3'd0);
        send_word(MODE_TICK, 32'h0000_0200, 3'd0);
        send_word(MODE_IDLE, 32'hFFFF_FFFF, 3'd7);
        send_word(MODE_ON,   32'hFFFF_FFFF, 3'd7);
        send_word(MODE_TICK, 32'hFFFF_FFFF, 3'd7);

        set_style(STYLE_NEON);
        send_word(MODE_OFF,  32'd1000, 3'd0);
        send_word(MODE_ON,   32'd2000, 3'd0);
        send_word(MODE_TICK, 32'd2000, 3'd7);
        send_word(MODE_TICK, 32'd2999, 3'd0);
        send_word(MODE_TICK, 32'd3000, 3'd0);
        send_word(MODE_TICK, 32'd3999, 3'd0);
        send_word(MODE_TICK, 32'd4000, 3'd0);

        set_style(STYLE_FADE_IO);
        send_word(MODE_OFF,  32'h8000_0000, 3'd0);
        send_word(MODE_TICK, 32'h8000_0000, 3'd0);
        send_word(MODE_TICK, 32'h8000_03E7, 3'd0);
        send_word(MODE_TICK, 32'h8000_03E8, 3'd0);
        send_word(MODE_ON,   32'h8000_03E8, 3'd0);
        send_word(MODE_TICK, 32'h8000_0400, 3'd0);

        set_style(4'd15);
        send_word(MODE_TICK, 32'h8000_0500, 3'd0);

        set_style(STYLE_FIRE);
        send_word(MODE_TICK, 32'h8000_0000, 3'd0);
        send_word(MODE_TICK, 32'hFFFF_FFFF, 3'd0);
    endtask

    // Walk every style with mostly coherent event/tick streams on a running
    // clock, mixed with redundant switches, ignored words and random noise
    task automatic test_random_styles(input int gap_pct, input int stall_pct,
                                      input logic [STYLE_W-1:0] unused_style);
        logic [NOW_W-1:0]  clock_ms;
        logic [NOW_W-1:0]  now;
        logic [MODE_W-1:0] mode;
        logic [STYLE_W-1:0] sty;
        int                r;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < 10; k++) begin
            sty = (k < 9) ? k[STYLE_W-1:0] : unused_style;
            set_style(sty);
            // start some runs just below the wrap of the time counter
            clock_ms = ($urandom_range(3) == 0) ? 32'hFFFF_F800 + $urandom_range(32'h7FF)
                                                : $urandom;
            for (int n = 0; n < RUN_WORDS; n++) begin
                clock_ms += ($urandom_range(9) == 0) ? $urandom_range(1200, 300)
                                                     : $urandom_range(100);
                now = clock_ms;
                r = (n == 0) ? 0 : $urandom_range(99);
                if (r < 8)
                    mode = lamp_on ? MODE_OFF : MODE_ON;
                else if (r < 12)
                    mode = lamp_on ? MODE_ON : MODE_OFF;
                else if (r < 15)
                    mode = MODE_IDLE;
                else if (r < 25) begin
                    mode = MODE_W'($urandom_range(3));
                    now = $urandom;
                end else
                    mode = MODE_TICK;
                send_word(mode, now, PICK_W'($urandom_range(7)));
            end
        end
    endtask

    // Take result words under random stall and check each against the oldest due
    always @(posedge i_clk) begin
        t_light_word due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (brightness_due.size() == 0) begin
                $display("%0t unexpected word: expected none, got apply %0d brightness %0d",
                         $time, m_axis_tuser[0], m_axis_tdata[3:0]);
                mismatches++;
            end else begin
                due = brightness_due.pop_front();
                if (m_axis_tuser[0] !== due.apply) begin
                    $display("%0t apply mismatch: expected %0d, got %0d",
                             $time, due.apply, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tdata[3:0] !== due.level) begin
                    $display("%0t brightness mismatch: expected %0d, got %0d",
                             $time, due.level, m_axis_tdata[3:0]);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Drop the run if the block stops answering
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_styles(37, 65, 4'd15);
        test_random_styles(65, 37, 4'd9);
        test_random_styles(0, 0, STYLE_W'($urandom_range(14, 10)));
        // drain the pipeline, then give it a few more edges to misbehave
        s_axis_tvalid <= 1'b0;
        while (brightness_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
